>>> hw/rtl/sfb_pkg.sv
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types and constants for the stuffed frame builder with checksum.
// ----------------------------------------------------------------------------
package sfb_pkg;

  localparam int FRAME_CAPACITY_DEF = 64;

  localparam int MODE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int SUM_W    = 7;

  // A data byte equal to the trigger is followed by the stuffing byte.
  localparam logic [BYTE_W-1:0] STUFF_TRIGGER = 8'hFE;
  localparam logic [BYTE_W-1:0] STUFF_BYTE    = 8'hFF;

  // 0xFE + 3 reduced to the checksum width.
  localparam logic [SUM_W-1:0] CKS_BIAS = 7'h01;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_RAW    = 2'd1,
    MODE_DATA   = 2'd2,
    MODE_FINISH = 2'd3
  } sfb_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVF_BYTE  = 2'd1,
    ST_OVF_STUFF = 2'd2
  } sfb_status_t;

  typedef struct packed {
    logic              byte_valid;
    logic [BYTE_W-1:0] out_byte;
    sfb_status_t       status;
    logic              last;
  } sfb_item_t;

endpackage

>>> hw/rtl/sfb_in_if.sv
// ----------------------------------------------------------------------------
// sfb_in_if
// Command channel of the frame builder: mode and data byte.
// ----------------------------------------------------------------------------
interface sfb_in_if;
  logic                        valid;
  logic                        ready;
  logic [sfb_pkg::MODE_W-1:0]  mode;
  logic [sfb_pkg::BYTE_W-1:0]  data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

>>> hw/rtl/sfb_out_if.sv
// ----------------------------------------------------------------------------
// sfb_out_if
// Result channel of the frame builder: one frame byte or error per item.
// ----------------------------------------------------------------------------
interface sfb_out_if;
  logic                          valid;
  logic                          ready;
  logic                          byte_valid;
  logic [sfb_pkg::BYTE_W-1:0]    out_byte;
  logic [sfb_pkg::STATUS_W-1:0]  status;
  logic                          last;

  modport source (output valid, output byte_valid, output out_byte, output status,
                  output last, input ready);
  modport sink   (input valid, input byte_valid, input out_byte, input status,
                  input last, output ready);
endinterface

>>> hw/rtl/stuffed_frame_builder_checksum.sv
// ----------------------------------------------------------------------------
// stuffed_frame_builder_checksum
// Builds a byte-stuffed serial frame with a 7-bit checksum, one command at
// a time, and streams the appended bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries commands: clear, raw byte, stuffed data byte, finish.
//   out_ch carries result items: appended byte or an overflow status, with
//   last set on the final item belonging to a command.
//   A command is processed in the cycle it is accepted; its one or two
//   result items are written into a four-entry output queue and appear
//   on out_ch in order, behind any items still waiting there.
//   Commands with one result are accepted one per cycle while the receiver
//   keeps up; a 0xFE data byte yields two, which the single-item-per-cycle
//   queue read port cannot drain as fast, so in_ch.ready then drops.
//   Clear produces no result item.
//   in_ch.ready is high while the queue has room for two items, so commands
//   keep flowing while earlier results wait for the receiver. When the
//   receiver stalls, the queue fills and in_ch.ready drops; nothing is lost.
//   Reset (rst_n low, synchronous) empties the queue and clears the frame
//   length, running sum and previous byte.
// ----------------------------------------------------------------------------
module stuffed_frame_builder_checksum #(
  parameter int FRAME_CAPACITY = sfb_pkg::FRAME_CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sfb_in_if.sink       in_ch,
  sfb_out_if.source    out_ch
);

  localparam int LEN_W   = $clog2(FRAME_CAPACITY + 1);
  localparam int Q_DEPTH = 4;
  localparam int PTR_W   = 2;
  localparam int CNT_W   = 3;

  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(FRAME_CAPACITY);

  // Frame state.
  logic [LEN_W-1:0]            len_r, len_nxt;
  logic [sfb_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [sfb_pkg::BYTE_W-1:0]  prev_r, prev_nxt;

  // Output queue.
  sfb_pkg::sfb_item_t q_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  logic                       accept;
  logic                       pop;
  logic [1:0]                 n_push;
  sfb_pkg::sfb_item_t         item0, item1;
  sfb_pkg::sfb_mode_t         mode;
  logic [sfb_pkg::SUM_W-1:0]  sum1;
  logic [sfb_pkg::SUM_W-1:0]  cks;
  logic [LEN_W-1:0]           len_p1;
  logic                       full;

  assign mode   = sfb_pkg::sfb_mode_t'(in_ch.mode);
  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;

  assign in_ch.ready = (cnt_r <= CNT_W'(Q_DEPTH - 2));

  assign full   = (len_r >= CAP_LEN);
  assign len_p1 = len_r + LEN_W'(1);
  // The previous byte joins the sum only once a later byte is appended.
  assign sum1   = sum_r + ((len_r != '0) ? prev_r[sfb_pkg::SUM_W-1:0] : '0);
  assign cks    = (len_r >= LEN_W'(2))
                ? (sfb_pkg::CKS_BIAS - sum_r - sfb_pkg::SUM_W'(len_r)) : '0;

  always_comb begin
    len_nxt  = len_r;
    sum_nxt  = sum_r;
    prev_nxt = prev_r;
    n_push   = 2'd0;
    item0    = '{byte_valid: 1'b0, out_byte: '0, status: sfb_pkg::ST_OK, last: 1'b1};
    item1    = item0;
    if (accept) begin
      priority if (mode == sfb_pkg::MODE_CLEAR) begin
        len_nxt  = '0;
        sum_nxt  = '0;
        prev_nxt = '0;
      end else if (full) begin
        n_push        = 2'd1;
        item0.status  = sfb_pkg::ST_OVF_BYTE;
      end else if (mode == sfb_pkg::MODE_FINISH) begin
        n_push           = 2'd1;
        item0.byte_valid = 1'b1;
        item0.out_byte   = {1'b0, cks};
        len_nxt          = len_p1;
        sum_nxt          = sum1;
        prev_nxt         = {1'b0, cks};
      end else if (mode == sfb_pkg::MODE_RAW || in_ch.data_byte != sfb_pkg::STUFF_TRIGGER) begin
        n_push           = 2'd1;
        item0.byte_valid = 1'b1;
        item0.out_byte   = in_ch.data_byte;
        len_nxt          = len_p1;
        sum_nxt          = sum1;
        prev_nxt         = in_ch.data_byte;
      end else begin
        n_push           = 2'd2;
        item0.byte_valid = 1'b1;
        item0.out_byte   = sfb_pkg::STUFF_TRIGGER;
        item0.last       = 1'b0;
        if (len_p1 >= CAP_LEN) begin
          // The trigger byte fits, its stuffing byte does not.
          item1.status = sfb_pkg::ST_OVF_STUFF;
          len_nxt      = len_p1;
          sum_nxt      = sum1;
          prev_nxt     = sfb_pkg::STUFF_TRIGGER;
        end else begin
          item1.byte_valid = 1'b1;
          item1.out_byte   = sfb_pkg::STUFF_BYTE;
          len_nxt          = len_p1 + LEN_W'(1);
          sum_nxt          = sum1 + sfb_pkg::STUFF_TRIGGER[sfb_pkg::SUM_W-1:0];
          prev_nxt         = sfb_pkg::STUFF_BYTE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      sum_r    <= '0;
      prev_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      len_r    <= len_nxt;
      sum_r    <= sum_nxt;
      prev_r   <= prev_nxt;
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_push);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      cnt_r    <= cnt_r + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= item0;
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr_r + PTR_W'(1)] <= item1;
    end
  end

  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.byte_valid = q_r[rd_ptr_r].byte_valid;
  assign out_ch.out_byte   = q_r[rd_ptr_r].out_byte;
  assign out_ch.status     = q_r[rd_ptr_r].status;
  assign out_ch.last       = q_r[rd_ptr_r].last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(Q_DEPTH))
    else $error("output queue count exceeds depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[PTR_W-1:0])
    else $error("queue pointers disagree with count");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CAP_LEN)
    else $error("frame length exceeds capacity");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && mode == sfb_pkg::MODE_CLEAR |=> len_r == '0 && sum_r == '0)
    else $error("clear did not reset frame state");

  a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && mode != sfb_pkg::MODE_CLEAR |=> out_ch.valid)
    else $error("accepted command produced no visible result");
`endif

endmodule
